FILE: hdl/bfie_pkg.sv
package bfie_pkg;

    // byte index of any bit position an offset plus a length can reach
    localparam int BIDX_W = 7;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

FILE: hdl/bit_field_insert_extract.sv
// bit field insert / extract on a byte buffer, msb-first bit order
// input channel (s_valid / s_ready) takes one request word: s_req_type selects
// read (0) or write (1) of an s_bit_length bit field at s_bit_offset, where
// offset 0 is the msb of byte 0. a write stores the low bits of s_write_value.
// result channel (m_valid / m_ready) returns one word per request: the
// right-aligned field on a read, zero on a write, and m_range_error with a
// zero value when the field is empty, too long or runs past the buffer end.
// the buffer is one byte-wide synchronous ram with one read and one write port;
// the request walks the bytes it spans, one read-modify-write step per cycle
// with the read of the next byte overlapping the write back of the current one.
// a field spans n bytes (1 to 5); a rejected request loads its result at its
// first step. the next request is taken the cycle after the result is
// loaded, so no request is taken while the last one is still in progress.
// after reset a clearing pass writes zero to all BUFFER_BYTES bytes, one per
// cycle, before the first request is taken.
// the result sits in an output register: a stalled receiver does not block
// the next request, which waits only at its own final step for a free slot.
module bit_field_insert_extract #(
    parameter int BUFFER_BYTES   = 64,
    parameter int MAX_FIELD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [8:0]  s_bit_offset,
    input  logic [5:0]  s_bit_length,
    input  logic [31:0] s_write_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_value,
    output logic        m_range_error
);

    localparam int ADDR_W   = $clog2(BUFFER_BYTES);
    localparam int FW       = MAX_FIELD_BITS;
    localparam int BUF_BITS = BUFFER_BYTES * 8;

    // byte buffer
    logic [7:0] mem [BUFFER_BYTES];

    bfie_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]            clr_reg, clr_next;
    logic [bfie_pkg::BIDX_W-1:0]  cur_reg, cur_next;
    logic [bfie_pkg::BIDX_W-1:0]  last_reg, last_next;
    logic [2:0]                   s_reg, s_next;       // start bit within current byte
    logic [3:0]                   endb_reg, endb_next; // end bit (exclusive) in last byte
    logic                         type_reg, type_next;
    logic                         err_reg, err_next;
    logic [FW-1:0]                wv_reg, wv_next;     // write value, left-justified
    logic [FW-1:0]                acc_reg, acc_next;   // read accumulator

    logic                         m_valid_reg, m_valid_next;
    logic [31:0]                  m_value_reg, m_value_next;
    logic                         m_err_reg, m_err_next;

    logic [7:0]                   rd_data_reg;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_wa;
    logic [7:0]                   mem_wd;

    // request decode
    logic [9:0]                   in_sum;
    logic [9:0]                   in_endpos;
    logic                         in_err;
    logic [5:0]                   in_lshift;

    // per-byte step
    logic [3:0]                   e_w;
    logic [3:0]                   n_w;
    logic [3:0]                   sh_lo;
    logic [7:0]                   fmask;
    logic [7:0]                   rd_bits;
    logic [7:0]                   wr_bits;
    logic [7:0]                   new_byte;
    logic                         done;
    logic                         out_free;
    logic [bfie_pkg::BIDX_W-1:0]  cur_inc;

    assign in_sum    = {1'b0, s_bit_offset} + {4'b0, s_bit_length};
    assign in_endpos = in_sum - 10'd1;
    assign in_err    = (s_bit_length == 6'd0)
                    || (32'(s_bit_length) > 32'(MAX_FIELD_BITS))
                    || (32'(in_sum) > 32'(BUF_BITS));
    assign in_lshift = 6'(MAX_FIELD_BITS) - s_bit_length;

    assign e_w      = (cur_reg == last_reg) ? endb_reg : 4'd8;
    assign n_w      = e_w - {1'b0, s_reg};
    assign sh_lo    = 4'd8 - e_w;
    assign fmask    = (8'hFF >> s_reg) & (8'hFF << sh_lo);
    assign rd_bits  = (rd_data_reg & fmask) >> sh_lo;
    assign wr_bits  = wv_reg[FW-1 -: 8] >> (4'd8 - n_w);
    assign new_byte = (rd_data_reg & ~fmask) | ((wr_bits << sh_lo) & fmask);
    assign done     = err_reg || (cur_reg == last_reg);
    assign out_free = !m_valid_reg || m_ready;
    assign cur_inc  = cur_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bfie_pkg::ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        cur_reg     <= cur_next;
        last_reg    <= last_next;
        s_reg       <= s_next;
        endb_reg    <= endb_next;
        type_reg    <= type_next;
        err_reg     <= err_next;
        wv_reg      <= wv_next;
        acc_reg     <= acc_next;
        m_value_reg <= m_value_next;
        m_err_reg   <= m_err_next;
    end

    // buffer ram, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        s_next       = s_reg;
        endb_next    = endb_reg;
        type_next    = type_reg;
        err_next     = err_reg;
        wv_next      = wv_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_err_next   = m_err_reg;
        s_ready      = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = ADDR_W'(cur_inc);
        mem_we       = 1'b0;
        mem_wa       = ADDR_W'(cur_reg);
        mem_wd       = new_byte;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            bfie_pkg::ST_CLEAR: begin
                // zero sweep over the whole buffer
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = 8'h00;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(BUFFER_BYTES - 1)) begin
                    state_next = bfie_pkg::ST_IDLE;
                end
            end
            bfie_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // fetch the first byte right away
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(s_bit_offset[8:3]);
                    cur_next   = {1'b0, s_bit_offset[8:3]};
                    last_next  = in_endpos[9:3];
                    s_next     = s_bit_offset[2:0];
                    endb_next  = {1'b0, in_endpos[2:0]} + 4'd1;
                    type_next  = s_req_type;
                    err_next   = in_err;
                    wv_next    = s_write_value[FW-1:0] << in_lshift;
                    acc_next   = '0;
                    state_next = bfie_pkg::ST_RUN;
                end
            end
            bfie_pkg::ST_RUN: begin
                // hold everything while the final step waits for the output slot
                if (!done || out_free) begin
                    if (!err_reg) begin
                        mem_we   = (type_reg == bfie_pkg::REQ_WRITE);
                        acc_next = (acc_reg << n_w) | FW'(rd_bits);
                        wv_next  = wv_reg << n_w;
                        s_next   = 3'd0;
                    end
                    if (done) begin
                        m_valid_next = 1'b1;
                        m_err_next   = err_reg;
                        m_value_next = (err_reg || type_reg == bfie_pkg::REQ_WRITE)
                                     ? 32'd0 : 32'(acc_next);
                        state_next   = bfie_pkg::ST_IDLE;
                    end else begin
                        rd_en    = 1'b1;
                        cur_next = cur_inc;
                    end
                end
            end
            default: begin
                state_next = bfie_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_range_error = m_err_reg;

endmodule
